// ----- sv/depth_max_pyramid_builder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder assertion macros
// Clocked assertion helpers used by the back end of the block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_MAX_PYRAMID_BUILDER_UNIT_ASSERT_SVH
`define DEPTH_MAX_PYRAMID_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define DMPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked in every cycle, reset included.
`define DMPB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define DMPB_ASSERT(lbl, prop, msg)
`define DMPB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/dmpb_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder package
// Shared item types, codes and default sizes.
// ----------------------------------------------------------------------------
package dmpb_pkg;

    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_DEPTH_BITS = 24;
    localparam int MAX_LEVELS     = 16;
    localparam int LVL_W          = 4;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_BASE_WIDTH  = 1'b0;
    localparam logic REG_BASE_HEIGHT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [23:0] sample_depth;
        logic [3:0]  read_level;
        logic [7:0]  read_x;
        logic [7:0]  read_y;
    } t_cmd;

    typedef struct packed {
        logic [23:0] entry_depth;
        logic [8:0]  level_width;
        logic [8:0]  level_height;
        logic        in_range;
    } t_result;

    typedef enum logic {
        JOB_LOAD,
        JOB_READ
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [23:0] depth;
        logic [3:0]  level;
        logic [7:0]  x;
        logic [7:0]  y;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LVL,
        S_BLD
    } t_state;

endpackage

// ----- sv/depth_max_pyramid_builder_unit.sv -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder
// Hierarchical max-depth mip pyramid with load and read commands; loads trigger the build.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a rising edge with start high and busy low.
// A load item (opcode 0) stores one depth sample in raster order into
// level 0. The load that completes the image starts the build of every
// coarser level; each entry is the maximum of a 2x2 block of the level above.
// A read item (opcode 1) returns one entry, its level's sizes and an in-range
// flag on o_result, marked by o_valid for exactly one cycle. The receiver
// cannot stall; loads return nothing.
// Throughput: one item per cycle while no build runs. A read item leaves its
// queue slot once the back end is idle; its result appears in the cycle after.
// A build sets up each coarser level in turn and reads the four source
// entries of each new entry one after another, as the single read port of the
// pyramid memory delivers one source sample a cycle, then writes their max;
// the four-entry job queue fills meanwhile and busy then holds off new items.
// Reset clears the pyramid and load count and sets both sizes to 256; the
// pyramid memory itself is not cleared. A register write on the APB port
// restarts loading and discards the pyramid.
// ----------------------------------------------------------------------------
module depth_max_pyramid_builder_unit #(
    parameter int MAX_DIM    = dmpb_pkg::DEF_MAX_DIM,
    parameter int DEPTH_BITS = dmpb_pkg::DEF_DEPTH_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dmpb_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output dmpb_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dmpb_pkg::*;

    logic [8:0] r_base_width, r_base_height;
    logic       cfg_wr, cfg_clr;
    logic       push, full, q_valid, pop;
    t_job       f_job, q_job;

    // Register index sits in paddr bit 2; the low byte bits are ignored.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_clr = cfg_wr;
    assign prdata  = (paddr[2] == REG_BASE_HEIGHT) ? {23'b0, r_base_height}
                                                   : {23'b0, r_base_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_width  <= 9'd256;
            r_base_height <= 9'd256;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BASE_WIDTH) r_base_width <= pwdata[8:0];
            else r_base_height <= pwdata[8:0];
        end
    end

    dmpb_front u_front (
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_job   (f_job)
    );

    dmpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    dmpb_back #(
        .MAX_DIM    (MAX_DIM),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .i_base_w  (r_base_width),
        .i_base_h  (r_base_height),
        .i_cfg_clr (cfg_clr),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

// ----- sv/dmpb_front.sv -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder front end
// Accepts command items and turns them into jobs for the queue.
// ----------------------------------------------------------------------------
module dmpb_front (
    input  logic          i_start,
    input  dmpb_pkg::t_cmd i_cmd,
    input  logic          i_full,
    output logic          o_busy,
    output logic          o_push,
    output dmpb_pkg::t_job o_job
);
    import dmpb_pkg::*;

    assign o_busy = i_full;
    assign o_push = i_start & ~i_full;

    // Loads carry only the sample; reads carry only the level and coordinates.
    always_comb begin
        o_job = '0;
        if (i_cmd.opcode == OP_READ) begin
            o_job.kind  = JOB_READ;
            o_job.level = i_cmd.read_level;
            o_job.x     = i_cmd.read_x;
            o_job.y     = i_cmd.read_y;
        end else begin
            o_job.kind  = JOB_LOAD;
            o_job.depth = i_cmd.sample_depth;
        end
    end

endmodule

// ----- sv/dmpb_queue.sv -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dmpb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dmpb_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output dmpb_pkg::t_job o_job
);
    import dmpb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            pop_ok;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];
    assign pop_ok  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop_ok) r_rp <= r_rp + 1'b1;
            if (i_push && !pop_ok) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && pop_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

endmodule

// ----- sv/dmpb_back.sv -----
// ----------------------------------------------------------------------------
// Depth max pyramid builder back end
// Stores samples, builds the coarser levels and serves read jobs.
// ----------------------------------------------------------------------------
`include "depth_max_pyramid_builder_unit_assert.svh"
module dmpb_back #(
    parameter int MAX_DIM    = dmpb_pkg::DEF_MAX_DIM,
    parameter int DEPTH_BITS = dmpb_pkg::DEF_DEPTH_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dmpb_pkg::t_job    i_job,
    output logic              o_pop,
    input  logic [8:0]        i_base_w,
    input  logic [8:0]        i_base_h,
    input  logic              i_cfg_clr,
    output logic              o_valid,
    output dmpb_pkg::t_result o_result
);
    import dmpb_pkg::*;

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int PW          = 2 * DIM_W;
    localparam int STORE_DEPTH = (MAX_DIM * MAX_DIM * 4) / 3 + 2 * MAX_DIM + 8;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam logic [31:0] MAX_DIM_U = 32'(MAX_DIM);

    logic [DEPTH_BITS-1:0] mem [STORE_DEPTH];
    logic [DEPTH_BITS-1:0] rdata;
    logic                  we;
    logic [AW-1:0]         wa, ra;
    logic [DEPTH_BITS-1:0] wd;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_loaded;
    logic [LVL_W-1:0] r_built, r_n;
    logic [DIM_W-1:0] r_lw [MAX_LEVELS];
    logic [DIM_W-1:0] r_lh [MAX_LEVELS];
    logic [AW-1:0]    r_loff [MAX_LEVELS];
    logic [DIM_W-1:0] r_w, r_h, r_nw, r_nh, r_x, r_y, r_x0;
    logic [AW-1:0]    r_src, r_off, r_lstart, r_row0, r_row1;
    logic [2:0]       r_phase;
    logic [DEPTH_BITS-1:0] r_max;
    logic             r_rvalid, r_ok;
    logic [8:0]       r_rw, r_rh;

    logic [DIM_W-1:0] w_base, h_base, nw, nh, x1;
    logic [CNT_W-1:0] total;
    logic             is_load, is_read, load_last, last_x, last_y;
    logic [DIM_W-1:0] sel_w, sel_h;
    logic             hit, ok;
    logic [AW-1:0]    rd_addr;
    logic [DEPTH_BITS-1:0] cand;

    always_comb begin
        if (i_base_w == '0) w_base = DIM_W'(1);
        else if (32'(i_base_w) > MAX_DIM_U) w_base = DIM_W'(MAX_DIM);
        else w_base = DIM_W'(i_base_w);
        if (i_base_h == '0) h_base = DIM_W'(1);
        else if (32'(i_base_h) > MAX_DIM_U) h_base = DIM_W'(MAX_DIM);
        else h_base = DIM_W'(i_base_h);
    end

    assign total     = CNT_W'(PW'(w_base) * PW'(h_base));
    assign is_load   = i_valid && (i_job.kind == JOB_LOAD);
    assign is_read   = i_valid && (i_job.kind == JOB_READ);
    assign load_last = (r_loaded + 1'b1) == total;
    assign nw        = ((r_w >> 1) == '0) ? DIM_W'(1) : (r_w >> 1);
    assign nh        = ((r_h >> 1) == '0) ? DIM_W'(1) : (r_h >> 1);
    assign x1        = (r_w == DIM_W'(1)) ? r_x0 : r_x0 + 1'b1;
    assign last_x    = (r_x == r_nw - 1'b1);
    assign last_y    = (r_y == r_nh - 1'b1);

    // Read lookup of the level table and entry address.
    assign sel_w   = r_lw[i_job.level];
    assign sel_h   = r_lh[i_job.level];
    assign hit     = i_job.level < r_built;
    assign ok      = hit && (32'(i_job.x) < 32'(sel_w)) && (32'(i_job.y) < 32'(sel_h));
    assign rd_addr = r_loff[i_job.level] + AW'(AW'(i_job.y) * AW'(sel_w)) + AW'(i_job.x);
    assign cand    = (rdata > r_max) ? rdata : r_max;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (is_load && load_last) n_state = S_LVL;
            S_LVL: begin
                if (r_w == DIM_W'(1) && r_h == DIM_W'(1)) n_state = S_IDLE;
                else n_state = S_BLD;
            end
            S_BLD: if (r_phase == 3'd4 && last_x && last_y) n_state = S_LVL;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        we    = 1'b0;
        wa    = r_off;
        wd    = cand;
        ra    = rd_addr;
        unique case (r_state)
            S_IDLE: begin
                o_pop = i_valid;
                if (is_load) begin
                    we = 1'b1;
                    wa = AW'(r_loaded);
                    wd = DEPTH_BITS'(i_job.depth);
                end
            end
            S_BLD: begin
                we = (r_phase == 3'd4);
                unique case (r_phase)
                    3'd0:    ra = r_row0 + AW'(r_x0);
                    3'd1:    ra = r_row0 + AW'(x1);
                    3'd2:    ra = r_row1 + AW'(r_x0);
                    default: ra = r_row1 + AW'(x1);
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= '0;
            r_built  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= (r_state == S_IDLE) && is_read;
            if (i_cfg_clr) begin
                r_loaded <= '0;
                r_built  <= '0;
            end else if (r_state == S_IDLE && is_load) begin
                if (r_loaded == '0) r_built <= '0;
                r_loaded <= load_last ? '0 : r_loaded + 1'b1;
            end else if (r_state == S_LVL && n_state == S_IDLE) begin
                r_built <= r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && is_read) begin
            r_ok <= ok;
            r_rw <= hit ? 9'(sel_w) : '0;
            r_rh <= hit ? 9'(sel_h) : '0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (is_load && load_last) begin
                    r_lw[0]   <= w_base;
                    r_lh[0]   <= h_base;
                    r_loff[0] <= '0;
                    r_w       <= w_base;
                    r_h       <= h_base;
                    r_src     <= '0;
                    r_off     <= AW'(total);
                    r_n       <= LVL_W'(1);
                end
            end
            S_LVL: begin
                r_nw     <= nw;
                r_nh     <= nh;
                r_row0   <= r_src;
                r_row1   <= r_src + ((r_h == DIM_W'(1)) ? '0 : AW'(r_w));
                r_x      <= '0;
                r_y      <= '0;
                r_x0     <= '0;
                r_phase  <= '0;
                r_lstart <= r_off;
            end
            S_BLD: begin
                if (r_phase == 3'd1) r_max <= rdata;
                else if (r_phase != 3'd0) r_max <= cand;
                if (r_phase != 3'd4) begin
                    r_phase <= r_phase + 1'b1;
                end else begin
                    r_phase <= '0;
                    r_off   <= r_off + 1'b1;
                    if (!last_x) begin
                        r_x  <= r_x + 1'b1;
                        r_x0 <= r_x0 + DIM_W'(2);
                    end else begin
                        r_x    <= '0;
                        r_x0   <= '0;
                        r_y    <= r_y + 1'b1;
                        r_row0 <= r_row0 + AW'(r_w) + AW'(r_w);
                        r_row1 <= r_row0 + AW'(r_w) + AW'(r_w)
                                  + ((r_h == DIM_W'(1)) ? '0 : AW'(r_w));
                        if (last_y) begin
                            r_lw[r_n]   <= r_nw;
                            r_lh[r_n]   <= r_nh;
                            r_loff[r_n] <= r_lstart;
                            r_src       <= r_lstart;
                            r_w         <= r_nw;
                            r_h         <= r_nh;
                            r_n         <= r_n + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid                = r_rvalid;
    assign o_result.entry_depth   = r_ok ? 24'(rdata) : '0;
    assign o_result.level_width   = r_rw;
    assign o_result.level_height  = r_rh;
    assign o_result.in_range      = r_ok;

    `DMPB_ASSERT(a_phase_range, (r_state == S_BLD) |-> (r_phase <= 3'd4), "build phase out of range")
    `DMPB_ASSERT(a_no_pop_in_build, (r_state != S_IDLE) |-> !o_pop, "job taken while building")
    `DMPB_ASSERT(a_no_pyramid_in_build, (r_state == S_BLD) |-> (r_built == '0), "stale pyramid during build")
    `DMPB_ASSERT(a_result_follows_read, o_valid |-> $past(r_state == S_IDLE && is_read), "result without read")
    `DMPB_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_valid), "reset did not idle")

endmodule

// ----- dv/tb_depth_max_pyramid_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth max pyramid builder testbench
// Loads depth images of many sizes through the command port, lets the block
// build its max-depth pyramid and reads entries back. A scoreboard class holds
// its own pyramid model and checks every read result field by field.
// ----------------------------------------------------------------------------
module tb_depth_max_pyramid_builder_unit;
    import dmpb_pkg::*;

    localparam int MAX_DIM    = 256;
    localparam int CYCLE_LIMIT = 2000000;

    // Scoreboard: mirrors the pyramid store, the load count and the level
    // table, and queues the result that each accepted read item must give.
    class depth_pyramid_scoreboard;
        logic [23:0] depth_mem[int unsigned];
        int unsigned loaded;
        int unsigned levels_built;
        int unsigned reg_width;
        int unsigned reg_height;
        int unsigned lvl_wd[MAX_LEVELS];
        int unsigned lvl_ht[MAX_LEVELS];
        int unsigned lvl_base[MAX_LEVELS];
        t_result     expected_reads[$];
        int          errors;

        function new();
            loaded = 0;
            levels_built = 0;
            reg_width = MAX_DIM;
            reg_height = MAX_DIM;
            errors = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v);
            if (v < 1) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        // A size register write restarts loading and drops the pyramid.
        function void note_config(logic reg_sel, logic [8:0] value);
            if (reg_sel == REG_BASE_WIDTH) reg_width = value;
            else reg_height = value;
            loaded = 0;
            levels_built = 0;
        endfunction

        // Each coarser entry is the max of a 2x2 block whose second row and
        // column are clamped to the source edge.
        function void build_levels();
            int unsigned w, h, nw, nh, off, src, x0, x1, y0, y1, n;
            logic [23:0] m;
            w = clamp_size(reg_width);
            h = clamp_size(reg_height);
            lvl_wd[0] = w;
            lvl_ht[0] = h;
            lvl_base[0] = 0;
            off = w * h;
            n = 1;
            while ((w > 1 || h > 1) && n < MAX_LEVELS) begin
                nw = (w / 2 > 1) ? w / 2 : 1;
                nh = (h / 2 > 1) ? h / 2 : 1;
                src = lvl_base[n-1];
                for (int unsigned y = 0; y < nh; y++) begin
                    y0 = 2 * y;
                    y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
                    for (int unsigned x = 0; x < nw; x++) begin
                        x0 = 2 * x;
                        x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
                        m = depth_mem[src + y0 * w + x0];
                        if (depth_mem[src + y0 * w + x1] > m) m = depth_mem[src + y0 * w + x1];
                        if (depth_mem[src + y1 * w + x0] > m) m = depth_mem[src + y1 * w + x0];
                        if (depth_mem[src + y1 * w + x1] > m) m = depth_mem[src + y1 * w + x1];
                        depth_mem[off + y * nw + x] = m;
                    end
                end
                lvl_wd[n] = nw;
                lvl_ht[n] = nh;
                lvl_base[n] = off;
                off += nw * nh;
                w = nw;
                h = nh;
                n++;
            end
            levels_built = n;
        endfunction

        function void note_item(t_cmd c);
            int unsigned total;
            t_result r;
            if (c.opcode == OP_LOAD) begin
                total = clamp_size(reg_width) * clamp_size(reg_height);
                if (loaded == 0) levels_built = 0;
                if (loaded < total) begin
                    depth_mem[loaded] = c.sample_depth;
                    loaded++;
                end
                if (loaded >= total) begin
                    build_levels();
                    loaded = 0;
                end
            end else begin
                r = '0;
                if (c.read_level < levels_built) begin
                    r.level_width  = 9'(lvl_wd[c.read_level]);
                    r.level_height = 9'(lvl_ht[c.read_level]);
                    if (c.read_x < lvl_wd[c.read_level] && c.read_y < lvl_ht[c.read_level]) begin
                        r.entry_depth = depth_mem[lvl_base[c.read_level]
                                        + c.read_y * lvl_wd[c.read_level] + c.read_x];
                        r.in_range = 1'b1;
                    end
                end
                expected_reads.insert(expected_reads.size(), r);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_reads.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_reads.pop_front();
            if (got.entry_depth !== exp_r.entry_depth) begin
                $display("%0t: entry_depth expected %h actual %h",
                         $time, exp_r.entry_depth, got.entry_depth);
                errors++;
            end
            if (got.level_width !== exp_r.level_width) begin
                $display("%0t: level_width expected %0d actual %0d",
                         $time, exp_r.level_width, got.level_width);
                errors++;
            end
            if (got.level_height !== exp_r.level_height) begin
                $display("%0t: level_height expected %0d actual %0d",
                         $time, exp_r.level_height, got.level_height);
                errors++;
            end
            if (got.in_range !== exp_r.in_range) begin
                $display("%0t: in_range expected %0d actual %0d",
                         $time, exp_r.in_range, got.in_range);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_valid;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    depth_pyramid_scoreboard sb;
    int          items_sent;
    int          cycle_count;
    bit          gaps_on;

    depth_max_pyramid_builder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_valid(o_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Results cannot be held off, so every strobe is checked at its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    // Runaway guard for a hung handshake or a lost result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one item after a random gap. The item stays on the port until
    // an edge sees start high and busy low; busy is read as it stood before
    // that edge.
    task automatic send_item(t_cmd c);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_item(c);
        items_sent++;
    endtask

    task automatic idle_port();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic reg_sel, logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {23'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.note_config(reg_sel, value);
    endtask

    function automatic logic [23:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic t_cmd load_cmd(logic [23:0] d);
        t_cmd c;
        c = t_cmd'(45'({$urandom(), $urandom()}));
        c.opcode = OP_LOAD;
        c.sample_depth = d;
        return c;
    endfunction

    // Reads mostly land inside a built level; some step just past its
    // edges and some take fully random level and coordinates.
    function automatic t_cmd read_cmd();
        t_cmd c;
        int unsigned lv;
        c = t_cmd'(45'({$urandom(), $urandom()}));
        c.opcode = OP_READ;
        if ($urandom_range(0, 4) != 0 && sb.levels_built > 0) begin
            lv = $urandom_range(0, sb.levels_built);
            if (lv > MAX_LEVELS - 1) lv = MAX_LEVELS - 1;
            c.read_level = 4'(lv);
            if (lv < sb.levels_built) begin
                c.read_x = 8'($urandom_range(0, sb.lvl_wd[lv] > 255 ? 255 : sb.lvl_wd[lv]));
                c.read_y = 8'($urandom_range(0, sb.lvl_ht[lv] > 255 ? 255 : sb.lvl_ht[lv]));
            end
        end
        return c;
    endfunction

    // One phase: program both sizes, load a full image with reads mixed in,
    // read the pyramid, then maybe load part or all of a second image. The phase
    // ends with a read, which the block queues behind any build, so its
    // result marks the block as idle again.
    task automatic run_phase(logic [8:0] w_reg, logic [8:0] h_reg, int n_reads,
                             bit fixed_depth, logic [23:0] depth_val);
        int unsigned total;
        int unsigned partial;
        gaps_on = ($urandom_range(0, 3) != 0);
        write_reg(REG_BASE_WIDTH, w_reg);
        write_reg(REG_BASE_HEIGHT, h_reg);
        total = sb.clamp_size(w_reg) * sb.clamp_size(h_reg);
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 5) == 0) send_item(read_cmd());
            send_item(load_cmd(fixed_depth ? depth_val : pick_depth()));
        end
        for (int i = 0; i < n_reads; i++) send_item(read_cmd());
        if ($urandom_range(0, 2) == 0) begin
            partial = $urandom_range(1, total);
            for (int unsigned i = 0; i < partial; i++) begin
                send_item(load_cmd(pick_depth()));
                if ($urandom_range(0, 3) == 0) send_item(read_cmd());
            end
        end
        send_item(read_cmd());
        idle_port();
        while (sb.expected_reads.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [8:0] w_reg, h_reg;
        t_cmd c;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        items_sent = 0;
        gaps_on = 1'b0;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads before any pyramid exists, including the top
        // level index and the far corner.
        c = '0;
        c.opcode = OP_READ;
        send_item(c);
        c.read_level = 4'hF;
        c.read_x = 8'hFF;
        c.read_y = 8'hFF;
        send_item(c);
        idle_port();
        while (sb.expected_reads.size() != 0) @(posedge i_clk);
        // Single-sample image, a zero size register acting as one, an
        // oversized register acting as the maximum, and odd sizes that
        // drop their last column or row.
        run_phase(9'd1, 9'd1, 3, 1'b1, 24'h000000);
        run_phase(9'd0, 9'd511, 6, 1'b1, 24'hFFFFFF);
        run_phase(9'd256, 9'd0, 6, 1'b0, '0);
        run_phase(9'd3, 9'd5, 8, 1'b0, '0);

        // Random phases: mostly small images, now and then a long strip
        // reaching the size extremes.
        while (items_sent < 1200) begin
            if ($urandom_range(0, 7) == 0) begin
                w_reg = 9'($urandom_range(0, 511));
                h_reg = 9'($urandom_range(0, 2));
                if ($urandom_range(0, 1)) {w_reg, h_reg} = {h_reg, w_reg};
            end else begin
                w_reg = 9'($urandom_range(1, 12));
                h_reg = 9'($urandom_range(1, 12));
            end
            run_phase(w_reg, h_reg, $urandom_range(5, 40), 1'b0, '0);
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_reads.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
